// ===== src/drp_pkg.sv =====
package drp_pkg;
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FOCAL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_BASE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIV_OFF = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WIDTH = 3'd5;
  localparam int NumW = 49;
  localparam int DenW = 42;

  typedef struct packed {
    logic frame_start;
    logic [7:0] disparity;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic [23:0] packed_colour;
    logic divide_by_zero;
  } point_t;

  typedef struct packed {
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic signed [NumW-1:0] nz;
    logic signed [DenW-1:0] w;
    logic [23:0] colour;
  } job_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0] data;
  } cfg_t;
endpackage

// ===== src/drp_if.sv =====
interface drp_pix_if;
  logic valid;
  logic ready;
  drp_pkg::pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drp_pt_if;
  logic valid;
  logic ready;
  drp_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drp_cfg_if;
  logic valid;
  logic ready;
  drp_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/drp_front.sv =====
module drp_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input logic clk,
  input logic rst,
  drp_pix_if.sink pix,
  drp_cfg_if.sink cfg,
  output logic job_valid,
  output drp_pkg::job_t job,
  input logic job_ready
);
  import drp_pkg::*;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int CntW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);

  logic signed [31:0] offset_x, offset_y, focal_term, inverse_baseline, divisor_offset;
  logic [12:0] image_width;
  logic [CntW-1:0] column_count;
  logic [RowW-1:0] row_count;
  logic [CntW-1:0] col;
  logic [RowW-1:0] row;
  logic [CW:0] limit;
  logic signed [40:0] prod;
  logic take;

  assign cfg.ready = 1'b1;
  assign pix.ready = !job_valid || job_ready;
  assign take = pix.valid && pix.ready;
  assign col = pix.data.frame_start ? '0 : column_count;
  assign row = pix.data.frame_start ? '0 : row_count;

  always_comb begin
    if (image_width == 13'd0) limit = (CW+1)'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH)) limit = (CW+1)'(MAX_WIDTH);
    else limit = (CW+1)'(image_width);
  end

  assign prod = $signed({1'b0, pix.data.disparity}) * inverse_baseline;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      focal_term <= 32'sd65536;
      inverse_baseline <= '0;
      divisor_offset <= 32'sd65536;
      image_width <= 13'd640;
      column_count <= '0;
      row_count <= '0;
      job_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.data.index)
          REG_OFFSET_X: offset_x <= cfg.data.data;
          REG_OFFSET_Y: offset_y <= cfg.data.data;
          REG_FOCAL: focal_term <= cfg.data.data;
          REG_INV_BASE: inverse_baseline <= cfg.data.data;
          REG_DIV_OFF: divisor_offset <= cfg.data.data;
          REG_WIDTH: image_width <= cfg.data.data[12:0];
          default: ;
        endcase
      end
      if (take) begin
        job_valid <= pix.data.disparity != 8'd0;
        if ((CW+1)'(col) + (CW+1)'(1) >= limit) begin
          column_count <= '0;
          row_count <= (32'(row) + 1 >= MAX_HEIGHT) ? '0 : row + 1'b1;
        end else begin
          column_count <= col + 1'b1;
          row_count <= row;
        end
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job.nx <= $signed(NumW'({col, 16'd0})) + NumW'(offset_x);
      job.ny <= $signed(NumW'({row, 16'd0})) + NumW'(offset_y);
      job.nz <= NumW'(focal_term);
      job.w <= DenW'(divisor_offset) - DenW'(prod);
      job.colour <= {pix.data.red, pix.data.green, pix.data.blue};
    end
  end
endmodule

// ===== src/drp_back.sv =====
module drp_back (
  input logic clk,
  input logic rst,
  input logic job_valid,
  input drp_pkg::job_t job,
  output logic job_ready,
  drp_pt_if.source pt
);
  import drp_pkg::*;
  localparam int QW = NumW + 16;
  localparam int StepW = $clog2(QW + 1);

  logic busy;
  logic [StepW-1:0] step;
  logic [1:0] lane;
  logic [QW-1:0] quo;
  logic [DenW:0] rem;
  logic [DenW-1:0] den;
  logic neg;
  logic signed [NumW-1:0] num;
  job_t cur;
  logic [DenW:0] trial;
  logic signed [QW:0] q_s;
  logic signed [31:0] res;

  assign job_ready = !busy && !pt.valid;
  assign num = (lane == 2'd0) ? cur.nx : (lane == 2'd1) ? cur.ny : cur.nz;
  assign trial = {rem[DenW-1:0], quo[QW-1]} - {1'b0, den};
  assign q_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    if (cur.w == '0)
      res = (num > 0) ? 32'sh7FFFFFFF : (num < 0) ? 32'sh80000000 : 32'sd0;
    else if (q_s > $signed((QW+1)'(32'h7FFFFFFF))) res = 32'sh7FFFFFFF;
    else if (q_s < -$signed((QW+1)'(33'h80000000))) res = 32'sh80000000;
    else res = q_s[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pt.valid <= 1'b0;
    end else begin
      if (pt.valid && pt.ready) pt.valid <= 1'b0;
      if (job_valid && job_ready) begin
        cur <= job;
        busy <= 1'b1;
        lane <= 2'd0;
        step <= '0;
        den <= job.w[DenW-1] ? -job.w : job.w;
        neg <= job.nx[NumW-1] ^ job.w[DenW-1];
        quo <= {(job.nx[NumW-1] ? -job.nx : job.nx), 16'd0};
        rem <= '0;
      end else if (busy) begin
        if (step != StepW'(QW)) begin
          if (!trial[DenW]) rem <= trial;
          else rem <= {rem[DenW-1:0], quo[QW-1]};
          quo <= {quo[QW-2:0], !trial[DenW]};
          step <= step + 1'b1;
        end else begin
          case (lane)
            2'd0: pt.data.x_coord <= res;
            2'd1: pt.data.y_coord <= res;
            default: pt.data.z_coord <= res;
          endcase
          step <= '0;
          rem <= '0;
          if (lane == 2'd0) begin
            neg <= cur.ny[NumW-1] ^ cur.w[DenW-1];
            quo <= {(cur.ny[NumW-1] ? -cur.ny : cur.ny), 16'd0};
          end else begin
            neg <= cur.nz[NumW-1] ^ cur.w[DenW-1];
            quo <= {(cur.nz[NumW-1] ? -cur.nz : cur.nz), 16'd0};
          end
          lane <= lane + 1'b1;
          if (lane == 2'd2) begin
            busy <= 1'b0;
            pt.valid <= 1'b1;
            pt.data.packed_colour <= cur.colour;
            pt.data.divide_by_zero <= cur.w == '0;
          end
        end
      end
    end
  end
endmodule

// ===== src/disparity_reprojection_to_points.sv =====
// A pixel transaction is registered in the front as a job, then the back end runs
// three 65-step restoring divisions, one after another, on one divider.
// The back end takes no new job while it divides or while a point waits to be
// taken; zero-disparity pixels are consumed without a point while the job slot is free.
// Reset: synchronous rst restores register defaults and clears counters.
module disparity_reprojection_to_points #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input logic clk,
  input logic rst,
  drp_pix_if.sink pix,
  drp_cfg_if.sink cfg,
  drp_pt_if.source pt
);
  import drp_pkg::*;
  logic job_valid, job_ready;
  job_t job;

  drp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .pix, .cfg, .job_valid, .job, .job_ready
  );
  drp_back u_back (.clk, .rst, .job_valid, .job, .job_ready, .pt);
endmodule

// ===== tb/sv/tb_disparity_reprojection_to_points.sv =====
module tb_disparity_reprojection_to_points;
  import drp_pkg::*;

  localparam int MaxWidth = 4096;
  localparam int MaxHeight = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drp_pix_if pix ();
  drp_cfg_if cfg ();
  drp_pt_if pt ();

  disparity_reprojection_to_points #(
    .MAX_WIDTH(MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .pix(pix.sink),
    .cfg(cfg.sink),
    .pt(pt.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scene parameters, tracked on the testbench side.
  logic signed [31:0] q_off_x, q_off_y, q_focal, q_inv_base, q_div_off;
  logic [12:0] row_len;
  int unsigned col_pos, row_pos;

  pixel_t pixel_queue[$];
  point_t point_queue[$];
  int errors = 0;
  bit quiet = 1'b0;
  int pix_gap = 0;
  int pt_stall = 0;

  function automatic void add_pixel(input pixel_t p);
    pixel_queue.insert(pixel_queue.size(), p);
  endfunction

  function automatic logic signed [31:0] q_divide(longint num, longint w);
    longint q;
    if (w == 0) begin
      if (num > 0) return 32'sh7fffffff;
      if (num < 0) return 32'sh80000000;
      return 32'sd0;
    end
    q = (num * 65536) / w;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  task automatic project_pixel(input pixel_t p);
    longint w, nx, ny;
    int unsigned lim;
    point_t r;
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (p.disparity != 0) begin
      w = longint'(q_div_off) - longint'(p.disparity) * longint'(q_inv_base);
      nx = longint'(col_pos) * 65536 + longint'(q_off_x);
      ny = longint'(row_pos) * 65536 + longint'(q_off_y);
      r.x_coord = q_divide(nx, w);
      r.y_coord = q_divide(ny, w);
      r.z_coord = q_divide(longint'(q_focal), w);
      r.packed_colour = {p.red, p.green, p.blue};
      r.divide_by_zero = (w == 0);
      point_queue.insert(point_queue.size(), r);
    end
    lim = row_len;
    if (lim == 0) lim = 1;
    if (lim > MaxWidth) lim = MaxWidth;
    if (col_pos + 1 >= lim) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= MaxHeight) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    pt.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      pix_gap <= 0;
    end else begin
      if (pix.valid && pix.ready) project_pixel(pix.data);
      if (!pix.valid || pix.ready) begin
        if (pix_gap > 0) begin
          pix.valid <= 1'b0;
          pix_gap <= pix_gap - 1;
        end else if (pixel_queue.size() > 0) begin
          pix.valid <= 1'b1;
          pix.data <= pixel_queue.pop_front();
          if (!quiet && $urandom_range(0, 19) == 0) pix_gap <= $urandom_range(1, 10);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      pt.ready <= 1'b0;
      pt_stall <= 0;
    end else begin
      if (pt.valid && pt.ready) begin
        if (point_queue.size() == 0) begin
          $error("unexpected point transaction %p", pt.data);
          errors++;
        end else begin
          e = point_queue.pop_front();
          if (pt.data.x_coord !== e.x_coord) begin
            $error("x_coord exp %h got %h", e.x_coord, pt.data.x_coord); errors++;
          end
          if (pt.data.y_coord !== e.y_coord) begin
            $error("y_coord exp %h got %h", e.y_coord, pt.data.y_coord); errors++;
          end
          if (pt.data.z_coord !== e.z_coord) begin
            $error("z_coord exp %h got %h", e.z_coord, pt.data.z_coord); errors++;
          end
          if (pt.data.packed_colour !== e.packed_colour) begin
            $error("packed_colour exp %h got %h", e.packed_colour, pt.data.packed_colour);
            errors++;
          end
          if (pt.data.divide_by_zero !== e.divide_by_zero) begin
            $error("divide_by_zero exp %b got %b", e.divide_by_zero, pt.data.divide_by_zero);
            errors++;
          end
        end
      end
      if (pt_stall > 0) begin
        pt.ready <= 1'b0;
        pt_stall <= pt_stall - 1;
      end else begin
        pt.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 29) == 0) pt_stall <= $urandom_range(1, 10);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_OFFSET_X: q_off_x = val;
      REG_OFFSET_Y: q_off_y = val;
      REG_FOCAL: q_focal = val;
      REG_INV_BASE: q_inv_base = val;
      REG_DIV_OFF: q_div_off = val;
      REG_WIDTH: row_len = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold until both queues drain, then let the divider finish.
  task automatic drain();
    while (pixel_queue.size() > 0 || pix.valid || point_queue.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(bit start, bit any_zero);
    pixel_t p;
    p.frame_start = start;
    p.disparity = (any_zero && $urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    p.blue = 8'($urandom);
    p.green = 8'($urandom);
    p.red = 8'($urandom);
    return p;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 20)) << 16;
      3: return -(32'($urandom_range(1, 20)) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_scene(input int wlen);
    write_reg(REG_OFFSET_X, rand_q());
    write_reg(REG_OFFSET_Y, rand_q());
    write_reg(REG_FOCAL, rand_q());
    write_reg(REG_INV_BASE, $urandom_range(0, 1) ? rand_q() : 32'($urandom_range(0, 3)) << 12);
    write_reg(REG_DIV_OFF, rand_q());
    write_reg(REG_WIDTH, 32'(wlen));
  endtask

  initial begin
    int wl;
    q_off_x = 0; q_off_y = 0; q_focal = 32'sd65536;
    q_inv_base = 0; q_div_off = 32'sd65536; row_len = 13'd640;
    col_pos = 0; row_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults first, then extremes of fields and a zero divisor.
    add_pixel('{1'b1, 8'd255, 8'hff, 8'hff, 8'hff});
    add_pixel('{1'b0, 8'd0, 8'h12, 8'h34, 8'h56});
    add_pixel('{1'b0, 8'd1, 8'h00, 8'h00, 8'h00});
    drain();
    write_reg(REG_OFFSET_X, 32'h7fffffff);
    write_reg(REG_OFFSET_Y, 32'h80000000);
    write_reg(REG_FOCAL, 32'h80000000);
    write_reg(REG_INV_BASE, 32'h00010000);
    write_reg(REG_DIV_OFF, 32'h00020000);
    write_reg(REG_WIDTH, 32'd0);
    add_pixel('{1'b1, 8'd2, 8'haa, 8'h55, 8'haa});
    add_pixel('{1'b0, 8'd1, 8'h55, 8'haa, 8'h55});
    add_pixel('{1'b0, 8'd3, 8'h01, 8'h80, 8'hfe});
    drain();
    write_reg(REG_OFFSET_X, 32'h00000000);
    write_reg(REG_WIDTH, 32'hffffe003);
    for (int i = 0; i < 8; i++) add_pixel(rand_pixel(i == 0, 1'b1));
    drain();
    write_reg(REG_WIDTH, 32'd4096);
    write_reg(REG_INV_BASE, 32'h80000000);
    write_reg(REG_DIV_OFF, 32'h7fffffff);
    add_pixel(rand_pixel(1'b1, 1'b0));
    add_pixel('{1'b0, 8'd255, 8'h0f, 8'hf0, 8'h3c});
    drain();
    write_reg(REG_WIDTH, 32'd8191);
    write_reg(3'd7, 32'hdeadbeef);
    add_pixel(rand_pixel(1'b1, 1'b0));
    drain();

    for (int ph = 0; ph < 19; ph++) begin
      wl = (ph % 6 == 0) ? $urandom_range(4000, 4200) : $urandom_range(1, 12);
      set_scene(wl);
      if (ph == 17) quiet = 1'b1;
      for (int i = 0; i < 100; i++)
        add_pixel(rand_pixel(i == 0 || $urandom_range(0, 60) == 0, 1'b1));
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
